@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain expression checked at every rising clock edge.
// The check is off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ design/rrbp_pkg.sv @@
package rrbp_pkg;

   // Row store depth in bytes and the widths that follow from it.
   localparam int ROW_DEPTH = 8192;
   localparam int ADDR_W    = $clog2(ROW_DEPTH);
   localparam int CNT_W     = $clog2(ROW_DEPTH + 1);

   // Number of decimal digits needed to print any count up to the depth.
   function automatic int dec_digits(input int value);
      int v;
      int n;
      v = value;
      n = 1;
      while (v >= 10) begin
         v = v / 10;
         n = n + 1;
      end
      return n;
   endfunction

   localparam int DEC_DIGITS = dec_digits(ROW_DEPTH);
   localparam int BCD_W      = 4 * DEC_DIGITS;
   localparam int DIG_IDX_W  = (DEC_DIGITS > 1) ? $clog2(DEC_DIGITS) : 1;
   localparam int BCD_STEP_W = (CNT_W > 1) ? $clog2(CNT_W) : 1;

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAPPED_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_BITS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_BITS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_BITS   = 3'd4;

   // Input operation codes.
   localparam logic [1:0] OP_PIXEL   = 2'd0;
   localparam logic [1:0] OP_END_ROW = 2'd1;
   localparam logic [1:0] OP_PULL    = 2'd2;

   // Frame header characters.
   localparam logic [7:0] CHR_ESC     = 8'h1B;
   localparam logic [7:0] CHR_STAR    = 8'h2A;
   localparam logic [7:0] CHR_LOWER_B = 8'h62;
   localparam logic [7:0] CHR_UPPER_W = 8'h57;
   localparam logic [7:0] CHR_ZERO    = 8'h30;

   localparam logic [3:0] MAX_FIELD_BITS = 4'd8;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ESC,
      PH_STAR,
      PH_B,
      PH_DIGITS,
      PH_W,
      PH_DATA
   } emit_phase_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_PACK_A,
      SQ_PACK_B,
      SQ_PACK_C,
      SQ_FLUSH,
      SQ_BCD,
      SQ_READ,
      SQ_PUT
   } seq_state_type;

endpackage

@@ design/raster_row_bit_packer_unit.sv @@
// Raster row bit packer. Each pixel transaction on the req_ channel is packed
// into a row of bytes, most significant bit first: in mapped mode the palette
// index cut to index_bits low bits, in direct mode red, green and blue cut to
// red_bits, green_bits and blue_bits low bits (a width above eight counts as
// eight, a width of zero packs nothing). An end-of-row transaction pads the
// partial byte with zeros, drops trailing zero bytes and opens a frame; each
// pull transaction then returns one frame byte on the rsp_ channel: ESC, '*',
// 'b', the decimal byte count, 'W' and the data bytes, with rsp_tlast on the
// final byte. Pixels and row ends that arrive while a frame drains are taken
// and ignored, as are pulls with no frame open and opcode three. The row
// store holds 8192 bytes; further bytes of a row are dropped. The block works
// on one transaction at a time and needs no clearing pass after reset. A
// mapped pixel passes through packing state A only and a direct pixel through
// states A, B and C, because the packing unit and the single write port of
// the row store take one field per cycle. An end of row passes a flush step,
// then the byte count is converted to decimal one bit per cycle. A pull
// passes through accept, row store read and output load, and waits at the
// load while the output register is still full; that register lets a new
// transaction be accepted while a result still waits to be taken.
`include "assert_macros.svh"

module raster_row_bit_packer_unit (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_tdata, from bit 0 up: red[7:0], green[15:8], blue[23:16],
   // pixel_index[31:24].
   input  logic [31:0]                      req_tdata,
   // req_tuser: opcode[1:0].
   input  logic [1:0]                       req_tuser,

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata: out_byte[7:0].
   output logic [7:0]                       rsp_tdata,
   output logic                             rsp_tlast,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rrbp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rrbp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W     = rrbp_pkg::ADDR_W;
   localparam int CNT_W      = rrbp_pkg::CNT_W;
   localparam int BCD_W      = rrbp_pkg::BCD_W;
   localparam int DIG_IDX_W  = rrbp_pkg::DIG_IDX_W;
   localparam int BCD_STEP_W = rrbp_pkg::BCD_STEP_W;
   localparam int DEC_DIGITS = rrbp_pkg::DEC_DIGITS;

   // Sequencer and frame emission state.
   rrbp_pkg::seq_state_type  state_ff, state_in;
   rrbp_pkg::emit_phase_type phase_ff, phase_in;

   // Configuration registers.
   logic       mapped_ff,     mapped_in;
   logic [3:0] index_bits_ff, index_bits_in;
   logic [3:0] red_bits_ff,   red_bits_in;
   logic [3:0] green_bits_ff, green_bits_in;
   logic [3:0] blue_bits_ff,  blue_bits_in;

   // Captured pixel fields. Field A holds the index in mapped mode, else red.
   logic [7:0] field_a_ff, field_a_in;
   logic [7:0] green_ff,   green_in;
   logic [7:0] blue_ff,    blue_in;

   // Packing state.
   logic [7:0]       partial_ff, partial_in;
   logic [2:0]       pbc_ff,     pbc_in;
   logic [CNT_W-1:0] row_cnt_ff, row_cnt_in;
   logic [CNT_W-1:0] last_nz_ff, last_nz_in;
   logic [CNT_W-1:0] trimmed_ff, trimmed_in;
   logic [CNT_W-1:0] emit_ptr_ff, emit_ptr_in;

   // Binary to decimal conversion state.
   logic [CNT_W-1:0]      bin_ff,      bin_in;
   logic [BCD_W-1:0]      bcd_ff,      bcd_in;
   logic [BCD_STEP_W-1:0] bcd_step_ff, bcd_step_in;
   logic [DIG_IDX_W-1:0]  dig_idx_ff,  dig_idx_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff,  rsp_data_in;
   logic       rsp_last_ff,  rsp_last_in;

   // Shared packing unit.
   logic [3:0]  pk_bits;
   logic [3:0]  pk_n;
   logic [8:0]  pk_mask;
   logic [7:0]  pk_value;
   logic [15:0] pk_acc;
   logic [4:0]  pk_total;
   logic        pk_full;
   logic [3:0]  pk_rem;
   logic [15:0] pk_shifted;
   logic [7:0]  pk_rem_mask;

   // Flush of the partial byte at the end of a row.
   logic [2:0] fl_shift;
   logic [7:0] fl_byte;

   // Row store write request.
   logic       st_valid;
   logic [7:0] st_byte;
   logic       ram_we;
   logic [7:0] ram_rd_data;

   // Decimal conversion and digit selection.
   logic [BCD_W-1:0]     bcd_adj;
   logic [DIG_IDX_W-1:0] dig_top;
   logic [3:0]           dig_value;

   logic req_fire;
   logic rsp_free;
   logic frame_last;
   logic [CNT_W-1:0] ptr_next;

   assign req_tready = (state_ff == rrbp_pkg::SQ_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The shared packing unit appends one field of up to eight bits to the
   // partial byte and splits off a finished byte when eight bits are present.
   always_comb begin
      case (state_ff)
         rrbp_pkg::SQ_PACK_A: begin
            pk_bits  = mapped_ff ? index_bits_ff : red_bits_ff;
            pk_value = field_a_ff;
         end
         rrbp_pkg::SQ_PACK_B: begin
            pk_bits  = green_bits_ff;
            pk_value = green_ff;
         end
         default: begin
            pk_bits  = blue_bits_ff;
            pk_value = blue_ff;
         end
      endcase
      pk_n        = (pk_bits > rrbp_pkg::MAX_FIELD_BITS) ? rrbp_pkg::MAX_FIELD_BITS : pk_bits;
      pk_mask     = (9'd1 << pk_n) - 9'd1;
      pk_acc      = ({8'd0, partial_ff} << pk_n) | {8'd0, pk_value & pk_mask[7:0]};
      pk_total    = {2'd0, pbc_ff} + {1'b0, pk_n};
      pk_full     = (pk_total >= 5'd8);
      pk_rem      = pk_total[3:0] - 4'd8;
      pk_shifted  = pk_acc >> pk_rem;
      pk_rem_mask = (8'd1 << pk_rem[2:0]) - 8'd1;
   end

   // Left-justify the partial byte so the pad bits land at the low end.
   assign fl_shift = 3'd0 - pbc_ff;
   assign fl_byte  = partial_ff << fl_shift;

   always_comb begin
      case (state_ff)
         rrbp_pkg::SQ_PACK_A, rrbp_pkg::SQ_PACK_B, rrbp_pkg::SQ_PACK_C: begin
            st_valid = pk_full;
            st_byte  = pk_shifted[7:0];
         end
         rrbp_pkg::SQ_FLUSH: begin
            st_valid = (pbc_ff != 3'd0);
            st_byte  = fl_byte;
         end
         default: begin
            st_valid = 1'b0;
            st_byte  = fl_byte;
         end
      endcase
   end

   // Bytes past the end of the store are dropped.
   assign ram_we = st_valid && (row_cnt_ff < CNT_W'(rrbp_pkg::ROW_DEPTH));

   rrbp_ram #(
      .WIDTH (8),
      .DEPTH (rrbp_pkg::ROW_DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (row_cnt_ff[ADDR_W-1:0]),
      .wr_data (st_byte),
      .rd_addr (emit_ptr_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // One double-dabble step: add three to every digit of five or more.
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Most significant nonzero digit; a count of zero prints as one digit.
   always_comb begin
      dig_top = '0;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            dig_top = DIG_IDX_W'(i);
         end
      end
   end

   assign dig_value = bcd_ff[{dig_idx_ff, 2'b00} +: 4];
   assign ptr_next  = emit_ptr_ff + CNT_W'(1);

   always_comb begin
      case (phase_ff)
         rrbp_pkg::PH_W:    frame_last = (trimmed_ff == '0);
         rrbp_pkg::PH_DATA: frame_last = (ptr_next >= trimmed_ff);
         default:           frame_last = 1'b0;
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrbp_pkg::SQ_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  rrbp_pkg::OP_PIXEL: begin
                     if (phase_ff == rrbp_pkg::PH_IDLE) begin
                        state_in = rrbp_pkg::SQ_PACK_A;
                     end
                  end
                  rrbp_pkg::OP_END_ROW: begin
                     if (phase_ff == rrbp_pkg::PH_IDLE) begin
                        state_in = rrbp_pkg::SQ_FLUSH;
                     end
                  end
                  rrbp_pkg::OP_PULL: begin
                     if (phase_ff != rrbp_pkg::PH_IDLE) begin
                        state_in = rrbp_pkg::SQ_READ;
                     end
                  end
                  default: state_in = rrbp_pkg::SQ_IDLE;
               endcase
            end
         end
         rrbp_pkg::SQ_PACK_A: begin
            state_in = mapped_ff ? rrbp_pkg::SQ_IDLE : rrbp_pkg::SQ_PACK_B;
         end
         rrbp_pkg::SQ_PACK_B: state_in = rrbp_pkg::SQ_PACK_C;
         rrbp_pkg::SQ_PACK_C: state_in = rrbp_pkg::SQ_IDLE;
         rrbp_pkg::SQ_FLUSH:  state_in = rrbp_pkg::SQ_BCD;
         rrbp_pkg::SQ_BCD: begin
            if (bcd_step_ff == BCD_STEP_W'(CNT_W - 1)) begin
               state_in = rrbp_pkg::SQ_IDLE;
            end
         end
         rrbp_pkg::SQ_READ: state_in = rrbp_pkg::SQ_PUT;
         rrbp_pkg::SQ_PUT: begin
            if (rsp_free) begin
               state_in = rrbp_pkg::SQ_IDLE;
            end
         end
         default: state_in = rrbp_pkg::SQ_IDLE;
      endcase
   end

   // Datapath and output updates.
   always_comb begin
      phase_in      = phase_ff;
      mapped_in     = mapped_ff;
      index_bits_in = index_bits_ff;
      red_bits_in   = red_bits_ff;
      green_bits_in = green_bits_ff;
      blue_bits_in  = blue_bits_ff;
      field_a_in    = field_a_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      partial_in    = partial_ff;
      pbc_in        = pbc_ff;
      row_cnt_in    = row_cnt_ff;
      last_nz_in    = last_nz_ff;
      trimmed_in    = trimmed_ff;
      emit_ptr_in   = emit_ptr_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      bcd_step_in   = bcd_step_ff;
      dig_idx_in    = dig_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            rrbp_pkg::CSR_MAPPED_MODE: mapped_in     = csr_wdata[0];
            rrbp_pkg::CSR_INDEX_BITS:  index_bits_in = csr_wdata;
            rrbp_pkg::CSR_RED_BITS:    red_bits_in   = csr_wdata;
            rrbp_pkg::CSR_GREEN_BITS:  green_bits_in = csr_wdata;
            rrbp_pkg::CSR_BLUE_BITS:   blue_bits_in  = csr_wdata;
            default: ;
         endcase
      end

      if (ram_we) begin
         row_cnt_in = row_cnt_ff + CNT_W'(1);
         if (st_byte != 8'd0) begin
            last_nz_in = row_cnt_ff + CNT_W'(1);
         end
      end

      case (state_ff)
         rrbp_pkg::SQ_IDLE: begin
            if (req_fire) begin
               field_a_in = mapped_ff ? req_tdata[31:24] : req_tdata[7:0];
               green_in   = req_tdata[15:8];
               blue_in    = req_tdata[23:16];
            end
         end
         rrbp_pkg::SQ_PACK_A, rrbp_pkg::SQ_PACK_B, rrbp_pkg::SQ_PACK_C: begin
            if (pk_full) begin
               partial_in = pk_acc[7:0] & pk_rem_mask;
               pbc_in     = pk_rem[2:0];
            end else begin
               partial_in = pk_acc[7:0];
               pbc_in     = pk_total[2:0];
            end
         end
         rrbp_pkg::SQ_FLUSH: begin
            // The trimmed length is the position just past the last nonzero
            // byte of the row, including the flushed byte.
            if (ram_we && (st_byte != 8'd0)) begin
               trimmed_in = row_cnt_ff + CNT_W'(1);
            end else begin
               trimmed_in = last_nz_ff;
            end
            partial_in  = 8'd0;
            pbc_in      = 3'd0;
            row_cnt_in  = '0;
            last_nz_in  = '0;
            emit_ptr_in = '0;
            phase_in    = rrbp_pkg::PH_ESC;
            bin_in      = trimmed_in;
            bcd_in      = '0;
            bcd_step_in = '0;
         end
         rrbp_pkg::SQ_BCD: begin
            bcd_in      = {bcd_adj[BCD_W-2:0], bin_ff[CNT_W-1]};
            bin_in      = {bin_ff[CNT_W-2:0], 1'b0};
            bcd_step_in = bcd_step_ff + BCD_STEP_W'(1);
         end
         rrbp_pkg::SQ_PUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = frame_last;
               case (phase_ff)
                  rrbp_pkg::PH_ESC: begin
                     rsp_data_in = rrbp_pkg::CHR_ESC;
                     phase_in    = rrbp_pkg::PH_STAR;
                  end
                  rrbp_pkg::PH_STAR: begin
                     rsp_data_in = rrbp_pkg::CHR_STAR;
                     phase_in    = rrbp_pkg::PH_B;
                  end
                  rrbp_pkg::PH_B: begin
                     rsp_data_in = rrbp_pkg::CHR_LOWER_B;
                     dig_idx_in  = dig_top;
                     phase_in    = rrbp_pkg::PH_DIGITS;
                  end
                  rrbp_pkg::PH_DIGITS: begin
                     rsp_data_in = rrbp_pkg::CHR_ZERO + {4'd0, dig_value};
                     if (dig_idx_ff == '0) begin
                        phase_in = rrbp_pkg::PH_W;
                     end else begin
                        dig_idx_in = dig_idx_ff - DIG_IDX_W'(1);
                     end
                  end
                  rrbp_pkg::PH_W: begin
                     rsp_data_in = rrbp_pkg::CHR_UPPER_W;
                     emit_ptr_in = '0;
                     phase_in    = frame_last ? rrbp_pkg::PH_IDLE : rrbp_pkg::PH_DATA;
                  end
                  rrbp_pkg::PH_DATA: begin
                     rsp_data_in = ram_rd_data;
                     if (frame_last) begin
                        emit_ptr_in = '0;
                        phase_in    = rrbp_pkg::PH_IDLE;
                     end else begin
                        emit_ptr_in = ptr_next;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_tready;
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rrbp_pkg::SQ_IDLE;
         phase_ff      <= rrbp_pkg::PH_IDLE;
         mapped_ff     <= 1'b0;
         index_bits_ff <= rrbp_pkg::MAX_FIELD_BITS;
         red_bits_ff   <= rrbp_pkg::MAX_FIELD_BITS;
         green_bits_ff <= rrbp_pkg::MAX_FIELD_BITS;
         blue_bits_ff  <= rrbp_pkg::MAX_FIELD_BITS;
         partial_ff    <= 8'd0;
         pbc_ff        <= 3'd0;
         row_cnt_ff    <= '0;
         last_nz_ff    <= '0;
         trimmed_ff    <= '0;
         emit_ptr_ff   <= '0;
         bcd_step_ff   <= '0;
         dig_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         mapped_ff     <= mapped_in;
         index_bits_ff <= index_bits_in;
         red_bits_ff   <= red_bits_in;
         green_bits_ff <= green_bits_in;
         blue_bits_ff  <= blue_bits_in;
         partial_ff    <= partial_in;
         pbc_ff        <= pbc_in;
         row_cnt_ff    <= row_cnt_in;
         last_nz_ff    <= last_nz_in;
         trimmed_ff    <= trimmed_in;
         emit_ptr_ff   <= emit_ptr_in;
         bcd_step_ff   <= bcd_step_in;
         dig_idx_ff    <= dig_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      field_a_ff  <= field_a_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // The row byte count never passes the store depth.
   `ASSERT_CLK(a_row_cnt_bound, clock, reset, row_cnt_ff <= CNT_W'(rrbp_pkg::ROW_DEPTH), "row count beyond store depth")
   // The last nonzero position always lies within the bytes written so far.
   `ASSERT_CLK(a_last_nz_bound, clock, reset, last_nz_ff <= row_cnt_ff, "last nonzero byte beyond row count")
   // While data bytes drain the read pointer stays inside the trimmed row.
   `ASSERT_CLK(a_data_ptr_bound, clock, reset, (phase_ff == rrbp_pkg::PH_DATA) |-> (emit_ptr_ff < trimmed_ff), "data pointer past trimmed length")
   // A result is only produced while a frame is open.
   `ASSERT_NEVER(a_put_without_frame, clock, reset, (state_ff == rrbp_pkg::SQ_PUT) && (phase_ff == rrbp_pkg::PH_IDLE), "result stage with no open frame")
   // The row store is only written while packing or flushing.
   `ASSERT_CLK(a_store_write_state, clock, reset, ram_we |-> (state_ff == rrbp_pkg::SQ_PACK_A || state_ff == rrbp_pkg::SQ_PACK_B || state_ff == rrbp_pkg::SQ_PACK_C || state_ff == rrbp_pkg::SQ_FLUSH), "row store written outside packing")

endmodule

@@ design/rrbp_ram.sv @@
module rrbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
